@@ rtl/assert_macros.svh @@
// Assertion macros used by first_fit_bin_packer_core.
// No dependencies; bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

@@ rtl/ffbp_pkg.sv @@
// Types and constants of the first-fit bin packer.
// No dependencies; used by ffbp_cell and first_fit_bin_packer_core.
package ffbp_pkg;

	localparam int MAX_BINS = 64;
	localparam int SIZE_W   = 16;
	localparam int CNT_W    = $clog2(MAX_BINS + 1);

	typedef struct packed {
		logic [SIZE_W-1:0] item_size;
		logic              first_of_set;
	} in_word_t;

	typedef struct packed {
		logic [5:0] bin_index;
		logic       opened_new;
		logic [6:0] bins_used;
		logic       rejected;
	} out_word_t;

	// word travelling down the cell chain
	typedef struct packed {
		logic              active;
		logic [SIZE_W-1:0] size;
		logic [CNT_W-1:0]  count;
		logic [CNT_W-1:0]  idx;
		logic              placed;
		logic              opened;
	} probe_t;

endpackage

@@ rtl/ffbp_cell.sv @@
// One bin of the packer chain: holds the bin's remaining space.
// Depends on ffbp_pkg.
module ffbp_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [ffbp_pkg::SIZE_W-1:0] cap,
	input  ffbp_pkg::probe_t          pin,
	output ffbp_pkg::probe_t          pout
);
	import ffbp_pkg::*;

	logic [SIZE_W-1:0] space_q;
	logic              is_open;
	logic              fit;
	logic              live;
	probe_t            nxt;

	assign is_open = pin.idx < pin.count;
	assign fit     = is_open && (space_q >= pin.size);
	assign live    = pin.active && !pin.placed;

	always_comb begin
		nxt = pin;
		if (live) begin
			if (fit) begin
				nxt.placed = 1'b1;
			end else if (!is_open) begin
				nxt.placed = 1'b1;
				nxt.opened = 1'b1;
			end else begin
				nxt.idx = CNT_W'(pin.idx + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (live && fit) begin
			space_q <= space_q - pin.size;
		end else if (live && !is_open) begin
			space_q <= cap - pin.size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pout <= '0;
		end else begin
			pout <= nxt;
		end
	end

endmodule

@@ rtl/first_fit_bin_packer_core.sv @@
// First-fit bin packer: a search word walks a chain of MAX_BINS bin cells, one per cycle.
// Launch word and each cell are registered; busy holds off a new start until done.
// An oversize item is rejected with done in the next cycle and busy stays low.
// Async reset clears the bin count and sets capacity to 100; bin space is unset until opened.
// Results are never held off; capacity writes wait until no item is in flight.
// Depends on ffbp_pkg, ffbp_cell and assert_macros.svh.
`include "assert_macros.svh"
module first_fit_bin_packer_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  ffbp_pkg::in_word_t          item,
	output logic                        done,
	output ffbp_pkg::out_word_t         result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ffbp_pkg::SIZE_W-1:0] cfg_data
);
	import ffbp_pkg::*;

	logic [SIZE_W-1:0] cap_q;
	logic [CNT_W-1:0]  open_bins_q;
	logic              busy_q;
	logic              done_q;
	out_word_t         result_q;
	probe_t            launch_q;
	probe_t            chain [MAX_BINS+1];
	probe_t            tail;
	logic              accept;
	logic              oversize;
	logic [CNT_W-1:0]  tail_used;
	logic [31:0]       idx_wide;
	logic [31:0]       used_wide;
	logic [31:0]       open_wide;

	assign accept    = start && !busy_q;
	assign oversize  = item.item_size > cap_q;
	assign cfg_ready = !busy_q && !start;
	assign busy      = busy_q;
	assign done      = done_q;
	assign result    = result_q;

	assign chain[0] = launch_q;
	assign tail     = chain[MAX_BINS];

	for (genvar j = 0; j < MAX_BINS; j++) begin : g_cell
		ffbp_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cap    (cap_q),
			.pin    (chain[j]),
			.pout   (chain[j+1])
		);
	end

	assign tail_used = tail.opened ? CNT_W'(tail.count + 1'b1) : tail.count;
	assign idx_wide  = 32'(tail.idx);
	assign used_wide = 32'(tail_used);
	assign open_wide = 32'(open_bins_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= SIZE_W'(100);
			open_bins_q <= '0;
			busy_q      <= 1'b0;
			done_q      <= 1'b0;
			launch_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			launch_q.active <= accept && !oversize;
			launch_q.size   <= item.item_size;
			launch_q.count  <= item.first_of_set ? '0 : open_bins_q;
			launch_q.idx    <= '0;
			launch_q.placed <= 1'b0;
			launch_q.opened <= 1'b0;
			done_q          <= 1'b0;
			if (accept && !oversize) begin
				busy_q <= 1'b1;
			end else if (accept) begin
				done_q <= 1'b1;
			end else if (tail.active) begin
				done_q <= 1'b1;
				busy_q <= 1'b0;
				if (tail.placed) begin
					open_bins_q <= tail_used;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && oversize) begin
			result_q.bin_index  <= '0;
			result_q.opened_new <= 1'b0;
			result_q.bins_used  <= open_wide[6:0];
			result_q.rejected   <= 1'b1;
		end else if (tail.active) begin
			result_q.bin_index  <= tail.placed ? idx_wide[5:0] : '0;
			result_q.opened_new <= tail.opened;
			result_q.bins_used  <= used_wide[6:0];
			result_q.rejected   <= !tail.placed;
		end
	end

	`ASSERT_NEXT(a_oversize_rejects, clk, arst_n, accept && oversize, done && result.rejected)
	`ASSERT_NEXT(a_accept_busy, clk, arst_n, accept && !oversize, busy)
	`ASSERT_IMPLIES(a_new_not_rejected, clk, arst_n, done && result.opened_new, !result.rejected)
	`ASSERT_IMPLIES(a_tail_only_busy, clk, arst_n, tail.active, busy_q)

endmodule

@@ verif/first_fit_bin_packer_core_test.sv @@
// Self-checking testbench for first_fit_bin_packer_core: directed and random item streams.
// A first-fit placement predictor runs alongside the core and checks every result word.
// Depends on ffbp_pkg and the first_fit_bin_packer_core RTL.
module first_fit_bin_packer_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import ffbp_pkg::*;

	localparam int ITEM_COUNT   = 1850;
	localparam int PHASE_ITEMS  = 230;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = MAX_BINS + 16;
	localparam int PRINT_LIMIT  = 40;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	in_word_t          item;
	logic              done;
	out_word_t         result;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [SIZE_W-1:0] cfg_data;

	first_fit_bin_packer_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// predictor state
	logic [SIZE_W-1:0] capacity_now = 16'd100;
	logic [SIZE_W-1:0] space_left [MAX_BINS];
	int                bins_open = 0;
	out_word_t         placements_due [$];

	int mismatches     = 0;
	int items_accepted = 0;
	int refusals       = 0;
	int bins_opened    = 0;
	int capacity_sets  = 0;
	int cycle_count    = 0;
	int burst_left     = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("** first_fit_bin_packer_core: FAILED **");
			$finish;
		end
	end

	function automatic out_word_t place_item(input in_word_t w);
		out_word_t r;
		int        count;
		int        slot;
		r     = '0;
		count = w.first_of_set ? 0 : bins_open;
		slot  = -1;
		if (w.item_size > capacity_now) begin
			r.bins_used = 7'(bins_open);
			r.rejected  = 1'b1;
		end else begin
			for (int j = 0; j < count; j++)
				if (slot < 0 && space_left[j] >= w.item_size)
					slot = j;
			if (slot >= 0) begin
				space_left[slot] = space_left[slot] - w.item_size;
				bins_open        = count;
				r.bin_index      = 6'(slot);
				r.bins_used      = 7'(bins_open);
			end else if (count >= MAX_BINS) begin
				r.bins_used = 7'(bins_open);
				r.rejected  = 1'b1;
			end else begin
				space_left[count] = capacity_now - w.item_size;
				bins_open         = count + 1;
				r.bin_index       = 6'(count);
				r.opened_new      = 1'b1;
				r.bins_used       = 7'(bins_open);
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	always @(posedge clk) begin : result_monitor
		out_word_t want;
		if (arst_n) begin
			if (done) begin
				if (placements_due.size() == 0) begin
					report_mismatch("result word with no item outstanding");
				end else begin
					want = placements_due.pop_front();
					check_field("bin_index", 8'(result.bin_index), 8'(want.bin_index));
					check_field("opened_new", 8'(result.opened_new), 8'(want.opened_new));
					check_field("bins_used", 8'(result.bins_used), 8'(want.bins_used));
					check_field("rejected", 8'(result.rejected), 8'(want.rejected));
					refusals    += int'(want.rejected);
					bins_opened += int'(want.opened_new);
				end
			end
			if (cfg_valid && cfg_ready) begin
				capacity_now = cfg_data;
				capacity_sets++;
			end
			if (start && !busy) begin
				placements_due.push_back(place_item(item));
				items_accepted++;
			end
		end
	end

	task automatic send_word(input logic [SIZE_W-1:0] size, input logic first);
		@(negedge clk);
		start <= 1'b1;
		item  <= '{item_size: size, first_of_set: first};
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic pause(input int cycles);
		if (cycles > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	task automatic send_paced(input logic [SIZE_W-1:0] size, input logic first);
		int r;
		send_word(size, first);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(24, 1);
			r = $urandom_range(99, 0);
			if (r < 25)
				pause(0);
			else if (r < 90)
				pause($urandom_range(12, 1));
			else
				pause($urandom_range(90, 50));
		end
	endtask

	task automatic wait_idle;
		@(negedge clk);
		start <= 1'b0;
		while (placements_due.size() != 0 || busy) @(negedge clk);
	endtask

	task automatic set_capacity(input logic [SIZE_W-1:0] cap);
		wait_idle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= cap;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// reset capacity of 100; refused set start must leave the bins alone
	task automatic test_first_fit_order;
		send_word(16'd60, 1'b1);
		send_word(16'd50, 1'b0);
		send_word(16'd40, 1'b0);
		send_word(16'd10, 1'b0);
		send_word(16'd40, 1'b0);
		send_word(16'd0, 1'b0);
		send_word(16'd100, 1'b0);
		send_word(16'hFFFF, 1'b1);
		send_word(16'd101, 1'b0);
		send_word(16'd1, 1'b0);
		send_word(16'd100, 1'b1);
	endtask

	// open bins keep their space when the capacity changes
	task automatic test_capacity_extremes;
		set_capacity(16'hFFFF);
		send_word(16'hFFFF, 1'b1);
		send_word(16'hFFFF, 1'b0);
		send_word(16'd0, 1'b0);
		send_word(16'd32768, 1'b0);
		send_word(16'd32767, 1'b0);
		set_capacity(16'd100);
		send_word(16'd50, 1'b0);
		send_word(16'd50, 1'b0);
	endtask

	task automatic test_zero_capacity;
		set_capacity(16'd0);
		send_word(16'd0, 1'b1);
		send_word(16'd0, 1'b0);
		send_word(16'd1, 1'b0);
		send_word(16'hFFFF, 1'b1);
	endtask

	task automatic test_store_full;
		set_capacity(16'd1);
		send_word(16'd1, 1'b1);
		repeat (MAX_BINS - 1) send_word(16'd1, 1'b0);
		send_word(16'd1, 1'b0);
		send_word(16'd0, 1'b0);
		send_word(16'd2, 1'b0);
		send_word(16'd1, 1'b1);
	endtask

	task automatic test_random;
		int                sent;
		int                placed;
		int                set_len;
		int                bulky;
		int                r;
		logic [SIZE_W-1:0] cap;
		logic [SIZE_W-1:0] size;
		logic              first;
		sent = 0;
		for (int phase = 0; sent < ITEM_COUNT; phase++) begin
			case (phase % 6)
				0: cap = 16'hFFFF;
				1: cap = 16'd1;
				2: cap = SIZE_W'($urandom_range(300, 2));
				3: cap = SIZE_W'($urandom_range(65535, 1));
				4: cap = 16'd100;
				default: cap = SIZE_W'($urandom_range(4000, 1));
			endcase
			set_capacity(cap);
			placed = 0;
			while (placed < PHASE_ITEMS && sent < ITEM_COUNT) begin
				set_len = ($urandom_range(7, 0) == 0) ? $urandom_range(90, 64)
				                                      : $urandom_range(24, 1);
				// bulky sets put every placed item in a bin of its own
				bulky = int'($urandom_range(3, 0) == 0);
				for (int k = 0; k < set_len && sent < ITEM_COUNT; k++) begin
					r = $urandom_range(99, 0);
					if (r < 8 && cap != 16'hFFFF)
						size = SIZE_W'($urandom_range(65535, int'(cap) + 1));
					else if (bulky != 0)
						size = SIZE_W'($urandom_range(cap, cap / 2 + 1));
					else if (r < 11)
						size = cap;
					else if (r < 15)
						size = 16'd0;
					else if (r < 55)
						size = SIZE_W'($urandom_range(cap, 0));
					else
						size = SIZE_W'($urandom_range(cap / 4, 0));
					first = (k == 0) || ($urandom_range(39, 0) == 0);
					send_paced(size, first);
					placed++;
					sent++;
				end
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		item      = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_first_fit_order();
		test_capacity_extremes();
		test_zero_capacity();
		test_store_full();
		test_random();

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run covered %0d items under %0d capacity writes in %0d cycles.",
			items_accepted, capacity_sets, cycle_count);
		$display("Items refused: %0d, bins opened: %0d, mismatches: %0d.",
			refusals, bins_opened, mismatches);
		if (mismatches == 0 && placements_due.size() == 0) begin
			$display("** first_fit_bin_packer_core: PASSED **");
		end else begin
			$display("** first_fit_bin_packer_core: FAILED **");
		end
		$finish;
	end

endmodule
